FILE: sv/ring_remote_report_decoder_top_defines.svh
// assertion macros for the ring remote report decoder
// used by ring_remote_report_decoder_top; expects i_clk and i_rst_n in scope
`ifndef RING_REMOTE_REPORT_DECODER_TOP_DEFINES_SVH
`define RING_REMOTE_REPORT_DECODER_TOP_DEFINES_SVH

// checked only outside reset
`define RRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define RRD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/rrd_pkg.sv
// shared types and constants of the ring remote report decoder
// no dependencies
`timescale 1ns / 1ps

package rrd_pkg;

    localparam int BUTTON_COUNT = 10;

    typedef logic [BUTTON_COUNT-1:0] t_btn;
    typedef logic [7:0]              t_byte;

    typedef enum logic [1:0] {
        FUNC_REPORT      = 2'd0,
        FUNC_DISCONNECT  = 2'd1,
        FUNC_READ_CLICKS = 2'd2,
        FUNC_RESERVED    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        MODE_NONE = 3'd0,
        MODE_A    = 3'd1,
        MODE_B    = 3'd2,
        MODE_C    = 3'd3,
        MODE_D    = 3'd4
    } t_mode;

    // button masks
    localparam t_btn BTN_A     = 10'b00_0000_0001;
    localparam t_btn BTN_B     = 10'b00_0000_0010;
    localparam t_btn BTN_C     = 10'b00_0000_0100;
    localparam t_btn BTN_D     = 10'b00_0000_1000;
    localparam t_btn BTN_L1    = 10'b00_0001_0000;
    localparam t_btn BTN_L2    = 10'b00_0010_0000;
    localparam t_btn BTN_UP    = 10'b00_0100_0000;
    localparam t_btn BTN_DOWN  = 10'b00_1000_0000;
    localparam t_btn BTN_LEFT  = 10'b01_0000_0000;
    localparam t_btn BTN_RIGHT = 10'b10_0000_0000;
    localparam t_btn BTN_DIRS  = BTN_UP | BTN_DOWN | BTN_LEFT | BTN_RIGHT;

    // report byte values
    localparam t_byte TAG_KEY   = 8'h50;
    localparam t_byte TAG_KEY_A = 8'h52;
    localparam t_byte TAG_KEY_C = 8'h51;
    localparam t_byte JOY_UP    = 8'h10;
    localparam t_byte JOY_DOWN  = 8'h90;
    localparam t_byte JOY_LEFT  = 8'h40;
    localparam t_byte JOY_RIGHT = 8'h60;
    localparam t_byte AXIS_NEG  = 8'he4;
    localparam t_byte AXIS_POS  = 8'h1c;

    // state-independent classification of one item
    typedef struct packed {
        t_func func;
        logic  len1;
        logic  len2;
        logic  len4;
        logic  b0_00;
        logic  b0_01;
        logic  b0_02;
        logic  b0_04;
        logic  b0_10;
        logic  b0_20;
        logic  p_00_key;
        logic  p_01_key;
        logic  p_02_key;
        logic  p_10_keya;
        logic  p_08_keyc;
        logic  p_80_key;
        logic  p_40_key;
        logic  joy_up;
        logic  joy_down;
        logic  joy_left;
        logic  joy_right;
        logic  tail0;
        logic  b1_neg;
        logic  b1_pos;
        logic  b2_neg;
        logic  b2_pos;
        t_btn  clr_mask;
    } t_cls;

endpackage

FILE: sv/rrd_ifs.sv
// valid/ready channel interfaces of the ring remote report decoder
// depends on rrd_pkg
`timescale 1ns / 1ps

interface rrd_in_if;
    logic          valid;
    logic          ready;
    logic [1:0]    func;
    logic [3:0]    report_length;
    logic [7:0]    byte_zero;
    logic [7:0]    byte_one;
    logic [7:0]    byte_two;
    logic [7:0]    byte_three;
    rrd_pkg::t_btn click_clear_mask;

    modport source (
        output valid, func, report_length, byte_zero, byte_one, byte_two,
               byte_three, click_clear_mask,
        input  ready
    );
    modport sink (
        input  valid, func, report_length, byte_zero, byte_one, byte_two,
               byte_three, click_clear_mask,
        output ready
    );
endinterface

interface rrd_out_if;
    logic          valid;
    logic          ready;
    logic [2:0]    mode_now;
    rrd_pkg::t_btn pressed_bits;
    rrd_pkg::t_btn clicked_bits;
    logic          unexpected_flag;

    modport source (
        output valid, mode_now, pressed_bits, clicked_bits, unexpected_flag,
        input  ready
    );
    modport sink (
        input  valid, mode_now, pressed_bits, clicked_bits, unexpected_flag,
        output ready
    );
endinterface

FILE: sv/rrd_front.sv
// front end: takes input transfers and classifies the report bytes
// depends on rrd_pkg and rrd_ifs
`timescale 1ns / 1ps

module rrd_front (
    rrd_in_if.sink       i_in,
    output logic         o_push_valid,
    output rrd_pkg::t_cls o_push_data,
    input  logic         i_push_ready
);
    import rrd_pkg::*;

    t_byte b0, b1, b2, b3;
    logic  b0_zero;

    assign b0 = i_in.byte_zero;
    assign b1 = i_in.byte_one;
    assign b2 = i_in.byte_two;
    assign b3 = i_in.byte_three;
    assign b0_zero = (b0 == 8'h00);

    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    always_comb begin
        o_push_data.func      = t_func'(i_in.func);
        o_push_data.len1      = (i_in.report_length == 4'd1);
        o_push_data.len2      = (i_in.report_length == 4'd2);
        o_push_data.len4      = (i_in.report_length == 4'd4);
        o_push_data.b0_00     = b0_zero;
        o_push_data.b0_01     = (b0 == 8'h01);
        o_push_data.b0_02     = (b0 == 8'h02);
        o_push_data.b0_04     = (b0 == 8'h04);
        o_push_data.b0_10     = (b0 == 8'h10);
        o_push_data.b0_20     = (b0 == 8'h20);
        o_push_data.p_00_key  = b0_zero && (b1 == TAG_KEY);
        o_push_data.p_01_key  = (b0 == 8'h01) && (b1 == TAG_KEY);
        o_push_data.p_02_key  = (b0 == 8'h02) && (b1 == TAG_KEY);
        o_push_data.p_10_keya = (b0 == 8'h10) && (b1 == TAG_KEY_A);
        o_push_data.p_08_keyc = (b0 == 8'h08) && (b1 == TAG_KEY_C);
        o_push_data.p_80_key  = (b0 == 8'h80) && (b1 == TAG_KEY);
        o_push_data.p_40_key  = (b0 == 8'h40) && (b1 == TAG_KEY);
        o_push_data.joy_up    = b0_zero && (b1 == JOY_UP);
        o_push_data.joy_down  = b0_zero && (b1 == JOY_DOWN);
        o_push_data.joy_left  = b0_zero && (b1 == JOY_LEFT);
        o_push_data.joy_right = b0_zero && (b1 == JOY_RIGHT);
        o_push_data.tail0     = (b1 == 8'h00) && (b2 == 8'h00) && (b3 == 8'h00);
        o_push_data.b1_neg    = (b1 == AXIS_NEG);
        o_push_data.b1_pos    = (b1 == AXIS_POS);
        o_push_data.b2_neg    = (b2 == AXIS_NEG);
        o_push_data.b2_pos    = (b2 == AXIS_POS);
        o_push_data.clr_mask  = i_in.click_clear_mask;
    end

endmodule

FILE: sv/rrd_queue.sv
// two-entry queue of classified items between front and back end
// depends on rrd_pkg
`timescale 1ns / 1ps

module rrd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  rrd_pkg::t_cls i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output rrd_pkg::t_cls o_pop_data,
    input  logic          i_pop_ready
);
    import rrd_pkg::*;

    t_cls       r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push_fire;
    logic       pop_fire;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push_fire    = i_push_valid && o_push_ready;
    assign pop_fire     = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_fire) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push_fire && !pop_fire) begin
                r_count <= r_count + 2'd1;
            end else if (pop_fire && !push_fire) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: sv/rrd_back.sv
// back end: mode tracking, button bitmaps and the output register
// depends on rrd_pkg and rrd_ifs
`timescale 1ns / 1ps

module rrd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    input  rrd_pkg::t_cls i_pop_data,
    output logic          o_pop_ready,
    rrd_out_if.source     o_out
);
    import rrd_pkg::*;

    t_mode r_mode, n_mode;
    t_btn  r_pressed, n_pressed;
    t_btn  r_clicked, n_clicked;
    t_btn  clicked_res;
    logic  unexp;

    logic  r_out_valid;
    t_mode r_out_mode;
    t_btn  r_out_pressed;
    t_btn  r_out_clicked;
    logic  r_out_unexp;

    logic  pop_fire;
    t_cls  it;

    assign it          = i_pop_data;
    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign pop_fire    = i_pop_valid && o_pop_ready;

    // next mode
    always_comb begin
        t_mode det;
        logic  joy;
        det    = r_mode;
        joy    = it.len2 && (it.joy_up || it.joy_down || it.joy_left || it.joy_right);
        n_mode = r_mode;
        if (pop_fire) begin
            case (it.func)
                FUNC_REPORT: begin
                    if (it.len4) begin
                        det = MODE_D;
                    end else if (it.len1 && (it.b0_04 || it.b0_10 || it.b0_20)) begin
                        det = MODE_A;
                    end else if (it.len2 && (it.p_10_keya || it.p_08_keyc ||
                                             it.p_80_key || it.p_40_key)) begin
                        det = MODE_B;
                    end
                    if (det != r_mode) begin
                        n_mode = det;
                    end else begin
                        case (r_mode)
                            MODE_A: begin
                                if (joy || (it.len2 && it.p_01_key)) n_mode = MODE_NONE;
                            end
                            MODE_B: begin
                                if (it.len1 && (it.b0_02 || it.b0_01)) n_mode = MODE_NONE;
                            end
                            MODE_C: begin
                                if ((it.len1 && it.b0_01) ||
                                    (it.len2 && (it.p_01_key || it.p_02_key))) begin
                                    n_mode = MODE_NONE;
                                end
                            end
                            MODE_D: begin
                                if (joy) n_mode = MODE_NONE;
                            end
                            default: ;
                        endcase
                    end
                end
                FUNC_DISCONNECT: n_mode = MODE_NONE;
                default: ;
            endcase
        end
    end

    // bitmaps and flag under the new mode
    always_comb begin
        t_btn p;
        t_btn c;
        logic joy_hit;
        t_btn joy_btn;
        p       = r_pressed;
        c       = r_clicked;
        unexp   = 1'b0;
        joy_hit = it.joy_up || it.joy_down || it.joy_left || it.joy_right;
        joy_btn = it.joy_up   ? BTN_UP   :
                  it.joy_down ? BTN_DOWN :
                  it.joy_left ? BTN_LEFT :
                  it.joy_right ? BTN_RIGHT : '0;
        case (it.func)
            FUNC_REPORT: begin
                if (n_mode != r_mode) begin
                    p = '0;
                    c = '0;
                end
                case (n_mode)
                    MODE_A: begin
                        if (it.len1) begin
                            if (it.b0_00) p = p & ~(BTN_A | BTN_C | BTN_D | BTN_DIRS);
                            else if (it.b0_01) begin
                                p = p | BTN_D | BTN_UP;
                                c = c | BTN_D;
                            end else if (it.b0_02) begin
                                p = p | BTN_C | BTN_DOWN;
                                c = c | BTN_C;
                            end else if (it.b0_04) begin
                                p = p | BTN_A;
                                c = c | BTN_A;
                            end else if (it.b0_10) p = p | BTN_LEFT;
                            else if (it.b0_20) p = p | BTN_RIGHT;
                            else unexp = 1'b1;
                        end else if (it.len2) begin
                            if (it.p_00_key) p = p & ~BTN_L1;
                            else if (it.p_02_key) begin
                                p = p | BTN_L1;
                                c = c | BTN_L1;
                            end else unexp = 1'b1;
                        end else begin
                            unexp = 1'b1;
                        end
                    end
                    MODE_B: begin
                        if (!it.len2) unexp = 1'b1;
                        else if (it.p_00_key) p = '0;
                        else if (it.p_10_keya) p = p | BTN_A;
                        else if (it.p_01_key) p = p | BTN_B;
                        else if (it.p_08_keyc) p = p | BTN_C;
                        else if (it.p_02_key) p = p | BTN_D;
                        else if (it.p_80_key) p = p | BTN_L1;
                        else if (it.p_40_key) p = p | BTN_L2;
                        else if (joy_hit) p = p | joy_btn;
                        else unexp = 1'b1;
                    end
                    MODE_C: begin
                        if (it.len1) begin
                            if (it.b0_00) p = p & ~BTN_C;
                            else if (it.b0_02) begin
                                p = p | BTN_C;
                                c = c | BTN_C;
                            end else unexp = 1'b1;
                        end else if (it.len2) begin
                            if (it.p_00_key) p = p & ~BTN_DIRS;
                            else if (joy_hit) p = p | joy_btn;
                            else unexp = 1'b1;
                        end else begin
                            unexp = 1'b1;
                        end
                    end
                    MODE_D: begin
                        if (it.len1) begin
                            if (it.b0_00) p = p & ~(BTN_C | BTN_D);
                            else if (it.b0_01) begin
                                p = p | BTN_C;
                                c = c | BTN_C;
                            end else if (it.b0_02) begin
                                p = p | BTN_D;
                                c = c | BTN_D;
                            end else unexp = 1'b1;
                        end else if (it.len2) begin
                            if (it.p_00_key) p = p & ~(BTN_A | BTN_B);
                            else if (it.p_01_key) p = p | BTN_A;
                            else if (it.p_02_key) p = p | BTN_B;
                            else unexp = 1'b1;
                        end else if (it.len4) begin
                            if (it.tail0 && it.b0_00) begin
                                p = p & ~(BTN_L1 | BTN_L2 | BTN_DIRS);
                            end else if (it.tail0 && it.b0_02) begin
                                p = p | BTN_L1;
                                c = c | BTN_L1;
                            end else if (it.tail0 && it.b0_01) begin
                                p = (p | BTN_L2) & ~BTN_DIRS;
                                c = c | BTN_L2;
                            end else begin
                                // analog fallback: l2 follows byte zero, then the axes
                                if (it.b0_01) p = p | BTN_L2;
                                else p = p & ~BTN_L2;
                                if (it.b1_neg) p = (p & ~BTN_DIRS) | BTN_LEFT;
                                else if (it.b1_pos) p = (p & ~BTN_DIRS) | BTN_RIGHT;
                                else if (it.b2_neg) p = (p & ~BTN_DIRS) | BTN_UP;
                                else if (it.b2_pos) p = (p & ~BTN_DIRS) | BTN_DOWN;
                                else unexp = 1'b1;
                            end
                        end else begin
                            unexp = 1'b1;
                        end
                    end
                    default: begin
                        // unknown mode: wipe, then a joystick report may press
                        p = '0;
                        c = '0;
                        if (it.len2 && joy_hit) p = joy_btn;
                    end
                endcase
            end
            FUNC_DISCONNECT: begin
                p = '0;
                c = '0;
            end
            default: ;
        endcase
        n_pressed   = p;
        clicked_res = c;
        n_clicked   = (it.func == FUNC_READ_CLICKS) ? (c & ~it.clr_mask) : c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NONE;
            r_pressed   <= '0;
            r_clicked   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode <= n_mode;
            if (pop_fire) begin
                r_pressed   <= n_pressed;
                r_clicked   <= n_clicked;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_fire) begin
            r_out_mode    <= n_mode;
            r_out_pressed <= n_pressed;
            r_out_clicked <= clicked_res;
            r_out_unexp   <= unexp;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.mode_now        = r_out_mode;
    assign o_out.pressed_bits    = r_out_pressed;
    assign o_out.clicked_bits    = r_out_clicked;
    assign o_out.unexpected_flag = r_out_unexp;

endmodule

FILE: sv/ring_remote_report_decoder_top.sv
// top level of the ring remote report decoder
// depends on rrd_pkg, rrd_ifs, rrd_front, rrd_queue, rrd_back and the defines header
//
//   port    dir  kind            payload
//   i_in    in   valid/ready     func, report_length, byte_zero..byte_three,
//                                click_clear_mask
//   o_out   out  valid/ready     mode_now, pressed_bits, clicked_bits,
//                                unexpected_flag
//
// one item per cycle sustained while the output is not stalled; each item takes
// one transfer in and gives one transfer out, via the queue and the output register
// the mode and bitmap update in the back end sets the rate
// i_rst_n is synchronous: mode goes to unknown, both bitmaps clear, queue empties
// a stalled output keeps its result in the output register; the two-entry
// queue keeps i_in ready until it fills
`timescale 1ns / 1ps
`include "ring_remote_report_decoder_top_defines.svh"

module ring_remote_report_decoder_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rrd_in_if.sink    i_in,
    rrd_out_if.source o_out
);
    import rrd_pkg::*;

    // front end to queue
    logic q_push_valid;
    t_cls q_push_data;
    logic q_push_ready;

    // queue to back end
    logic q_pop_valid;
    t_cls q_pop_data;
    logic q_pop_ready;

    // assertion terms
    logic pop_fire;
    logic out_unknown;
    logic out_clean;

    // classification only; no state, so the front end never stalls on its own
    rrd_front u_front (
        .i_in         (i_in),
        .o_push_valid (q_push_valid),
        .o_push_data  (q_push_data),
        .i_push_ready (q_push_ready)
    );

    // decouples input transfers from output back-pressure; ready is decoded from a register
    rrd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .i_push_data  (q_push_data),
        .o_push_ready (q_push_ready),
        .o_pop_valid  (q_pop_valid),
        .o_pop_data   (q_pop_data),
        .i_pop_ready  (q_pop_ready)
    );

    // mode inference, button decode and the output register
    rrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (q_pop_valid),
        .i_pop_data  (q_pop_data),
        .o_pop_ready (q_pop_ready),
        .o_out       (o_out)
    );

    assign pop_fire    = q_pop_valid && q_pop_ready;
    assign out_unknown = o_out.valid && (o_out.mode_now == MODE_NONE);
    assign out_clean   = (o_out.clicked_bits == '0) && !o_out.unexpected_flag;

    // nothing leaves the block in the cycle after reset
    `RRD_ASSERT_ALWAYS(a_no_out_after_reset, !i_rst_n |=> !o_out.valid, "output valid after reset")

    // every item taken from the queue shows up in the output register next cycle
    `RRD_ASSERT(a_pop_gives_result, pop_fire |=> o_out.valid, "popped item gave no result")

    // in unknown mode no click survives and nothing is flagged
    `RRD_ASSERT(a_unknown_clean, out_unknown |-> out_clean, "unknown mode with clicks or flag")

endmodule

FILE: verif/rrd_report_checker.sv
// transfer monitor and result check for the ring remote report decoder
// depends on rrd_pkg and rrd_ifs; instantiated beside the block by the bench top
`timescale 1ns / 1ps

module rrd_report_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rrd_in_if    i_in_mon,
    rrd_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending_count
);
    import rrd_pkg::*;

    typedef struct packed {
        logic [2:0] mode;
        t_btn       pressed;
        t_btn       clicked;
        logic       unmatched;
    } t_decoder_view;

    // decoder state as the block should hold it
    logic [2:0]    mode_q;
    t_btn          pressed_q;
    t_btn          clicked_q;
    t_decoder_view decoded_q[$];

    function automatic t_btn joystick_dir(input t_byte b0, input t_byte b1);
        if (b0 != 8'h00) return '0;
        case (b1)
            JOY_UP:    return BTN_UP;
            JOY_DOWN:  return BTN_DOWN;
            JOY_LEFT:  return BTN_LEFT;
            JOY_RIGHT: return BTN_RIGHT;
            default:   return '0;
        endcase
    endfunction

    task automatic latch_click(input t_btn m);
        pressed_q |= m;
        clicked_q |= m;
    endtask

    task automatic decode_remote_item(
        input  t_func         func,
        input  logic [3:0]    len,
        input  t_byte         b0,
        input  t_byte         b1,
        input  t_byte         b2,
        input  t_byte         b3,
        input  t_btn          clear_mask,
        output t_decoder_view view
    );
        logic [2:0] next_mode;
        t_btn       dir;
        logic       joy;
        logic       tail_zero;
        logic       unmatched;
        t_btn       clicked_seen;
        unmatched = 1'b0;
        dir       = joystick_dir(b0, b1);
        joy       = (len == 4'd2) && (dir != '0);
        tail_zero = (b1 == 8'h00) && (b2 == 8'h00) && (b3 == 8'h00);
        if (func == FUNC_REPORT) begin
            // signature reports pick the mode
            next_mode = mode_q;
            if (len == 4'd4) begin
                next_mode = MODE_D;
            end else if (len == 4'd1 && (b0 == 8'h04 || b0 == 8'h10 || b0 == 8'h20)) begin
                next_mode = MODE_A;
            end else if (len == 4'd2 && ((b0 == 8'h10 && b1 == TAG_KEY_A) ||
                         (b0 == 8'h08 && b1 == TAG_KEY_C) ||
                         (b0 == 8'h80 && b1 == TAG_KEY) || (b0 == 8'h40 && b1 == TAG_KEY))) begin
                next_mode = MODE_B;
            end
            // conflicting reports drop back to unknown
            if (next_mode == mode_q) begin
                case (mode_q)
                    MODE_A: if (joy || (len == 4'd2 && b0 == 8'h01 && b1 == TAG_KEY))
                        next_mode = MODE_NONE;
                    MODE_B: if (len == 4'd1 && (b0 == 8'h01 || b0 == 8'h02))
                        next_mode = MODE_NONE;
                    MODE_C: if ((len == 4'd1 && b0 == 8'h01) || (len == 4'd2 &&
                                b1 == TAG_KEY && (b0 == 8'h01 || b0 == 8'h02)))
                        next_mode = MODE_NONE;
                    MODE_D: if (joy) next_mode = MODE_NONE;
                    default: ;
                endcase
            end
            if (next_mode != mode_q) begin
                pressed_q = '0;
                clicked_q = '0;
                mode_q    = next_mode;
            end

            case (mode_q)
                MODE_A: begin
                    if (len == 4'd1) begin
                        case (b0)
                            8'h00: pressed_q &= ~(BTN_A | BTN_C | BTN_D | BTN_DIRS);
                            8'h01: begin
                                latch_click(BTN_D);
                                pressed_q |= BTN_UP;
                            end
                            8'h02: begin
                                latch_click(BTN_C);
                                pressed_q |= BTN_DOWN;
                            end
                            8'h04: latch_click(BTN_A);
                            8'h10: pressed_q |= BTN_LEFT;
                            8'h20: pressed_q |= BTN_RIGHT;
                            default: unmatched = 1'b1;
                        endcase
                    end else if (len == 4'd2 && b1 == TAG_KEY && b0 == 8'h00) begin
                        pressed_q &= ~BTN_L1;
                    end else if (len == 4'd2 && b1 == TAG_KEY && b0 == 8'h02) begin
                        latch_click(BTN_L1);
                    end else begin
                        unmatched = 1'b1;
                    end
                end
                MODE_B: begin
                    if (len != 4'd2) unmatched = 1'b1;
                    else if (b0 == 8'h00 && b1 == TAG_KEY) pressed_q = '0;
                    else if (b0 == 8'h10 && b1 == TAG_KEY_A) pressed_q |= BTN_A;
                    else if (b0 == 8'h01 && b1 == TAG_KEY) pressed_q |= BTN_B;
                    else if (b0 == 8'h08 && b1 == TAG_KEY_C) pressed_q |= BTN_C;
                    else if (b0 == 8'h02 && b1 == TAG_KEY) pressed_q |= BTN_D;
                    else if (b0 == 8'h80 && b1 == TAG_KEY) pressed_q |= BTN_L1;
                    else if (b0 == 8'h40 && b1 == TAG_KEY) pressed_q |= BTN_L2;
                    else if (dir != '0) pressed_q |= dir;
                    else unmatched = 1'b1;
                end
                MODE_C: begin
                    if (len == 4'd1 && b0 == 8'h00) pressed_q &= ~BTN_C;
                    else if (len == 4'd1 && b0 == 8'h02) latch_click(BTN_C);
                    else if (len == 4'd2 && b0 == 8'h00 && b1 == TAG_KEY) pressed_q &= ~BTN_DIRS;
                    else if (len == 4'd2 && dir != '0) pressed_q |= dir;
                    else unmatched = 1'b1;
                end
                MODE_D: begin
                    if (len == 4'd1) begin
                        case (b0)
                            8'h00:   pressed_q &= ~(BTN_C | BTN_D);
                            8'h01:   latch_click(BTN_C);
                            8'h02:   latch_click(BTN_D);
                            default: unmatched = 1'b1;
                        endcase
                    end else if (len == 4'd2) begin
                        if (b0 == 8'h00 && b1 == TAG_KEY) pressed_q &= ~(BTN_A | BTN_B);
                        else if (b0 == 8'h01 && b1 == TAG_KEY) pressed_q |= BTN_A;
                        else if (b0 == 8'h02 && b1 == TAG_KEY) pressed_q |= BTN_B;
                        else unmatched = 1'b1;
                    end else if (len == 4'd4) begin
                        if (tail_zero && b0 == 8'h00) begin
                            pressed_q &= ~(BTN_L1 | BTN_L2 | BTN_DIRS);
                        end else if (tail_zero && b0 == 8'h02) begin
                            latch_click(BTN_L1);
                        end else if (tail_zero && b0 == 8'h01) begin
                            latch_click(BTN_L2);
                            pressed_q &= ~BTN_DIRS;
                        end else begin
                            // axis fallback: l2 follows byte zero, then one direction
                            if (b0 == 8'h01) pressed_q |= BTN_L2;
                            else pressed_q &= ~BTN_L2;
                            if (b1 == AXIS_NEG) pressed_q = (pressed_q & ~BTN_DIRS) | BTN_LEFT;
                            else if (b1 == AXIS_POS) pressed_q = (pressed_q & ~BTN_DIRS) | BTN_RIGHT;
                            else if (b2 == AXIS_NEG) pressed_q = (pressed_q & ~BTN_DIRS) | BTN_UP;
                            else if (b2 == AXIS_POS) pressed_q = (pressed_q & ~BTN_DIRS) | BTN_DOWN;
                            else unmatched = 1'b1;
                        end
                    end else begin
                        unmatched = 1'b1;
                    end
                end
                default: begin
                    // unknown mode: wipe, then only joystick reports press
                    pressed_q = '0;
                    clicked_q = '0;
                    if (len == 4'd2) pressed_q |= dir;
                end
            endcase
        end else if (func == FUNC_DISCONNECT) begin
            pressed_q = '0;
            clicked_q = '0;
            mode_q    = MODE_NONE;
        end
        clicked_seen = clicked_q;
        if (func == FUNC_READ_CLICKS) clicked_q &= ~clear_mask;
        view.mode      = mode_q;
        view.pressed   = pressed_q;
        view.clicked   = clicked_seen;
        view.unmatched = unmatched;
    endtask

    always @(posedge i_clk) begin
        t_decoder_view want;
        if (!i_rst_n) begin
            mode_q    = MODE_NONE;
            pressed_q = '0;
            clicked_q = '0;
            decoded_q.delete();
            o_fail_count    = 0;
            o_pending_count = 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_remote_item(t_func'(i_in_mon.func), i_in_mon.report_length,
                                   i_in_mon.byte_zero, i_in_mon.byte_one, i_in_mon.byte_two,
                                   i_in_mon.byte_three, i_in_mon.click_clear_mask, want);
                decoded_q.push_back(want);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("output transfer with no input transfer outstanding");
                    o_fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_mon.mode_now !== want.mode) begin
                        $error("mode_now mismatch: expected %0d, actual %0d",
                               want.mode, i_out_mon.mode_now);
                        o_fail_count++;
                    end
                    if (i_out_mon.pressed_bits !== want.pressed) begin
                        $error("pressed_bits mismatch: expected %h, actual %h",
                               want.pressed, i_out_mon.pressed_bits);
                        o_fail_count++;
                    end
                    if (i_out_mon.clicked_bits !== want.clicked) begin
                        $error("clicked_bits mismatch: expected %h, actual %h",
                               want.clicked, i_out_mon.clicked_bits);
                        o_fail_count++;
                    end
                    if (i_out_mon.unexpected_flag !== want.unmatched) begin
                        $error("unexpected_flag mismatch: expected %0d, actual %0d",
                               want.unmatched, i_out_mon.unexpected_flag);
                        o_fail_count++;
                    end
                end
            end
            o_pending_count = decoded_q.size();
        end
    end

endmodule

FILE: verif/tb_ring_remote_report_decoder_top.sv
// bench top for the ring remote report decoder: clock, reset, stimulus, verdict
// depends on rrd_pkg, rrd_ifs, ring_remote_report_decoder_top and rrd_report_checker
`timescale 1ns / 1ps

module tb_ring_remote_report_decoder_top;
    import rrd_pkg::*;

    // cycles with no transfer on either side before the run is called hung
    localparam int IDLE_LIMIT   = 2000;
    // receiver hold-off long enough to fill the block and stall its input
    localparam int HOLD_CYCLES  = 64;
    // extra wait after the last result, before the verdict
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 130;

    typedef struct packed {
        t_func      func;
        logic [3:0] len;
        t_byte      b0;
        t_byte      b1;
        t_byte      b2;
        t_byte      b3;
        t_btn       mask;
    } t_remote_item;

    // which device mode a burst of random reports speaks
    typedef enum logic [1:0] {
        BURST_A,
        BURST_B,
        BURST_D
    } t_burst_kind;

    logic        i_clk;
    logic        i_rst_n;
    int          send_idle_pct;
    int          stall_pct;
    int          holds_asked;
    int          holds_done;
    int          fail_count;
    int          pending_count;
    t_burst_kind burst_kind;
    int          burst_left;

    rrd_in_if  in_ch ();
    rrd_out_if out_ch ();

    ring_remote_report_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rrd_report_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_remote_item pack_item(input t_func func, input logic [3:0] len,
                                               input t_byte b0, input t_byte b1,
                                               input t_byte b2, input t_byte b3,
                                               input t_btn mask);
        t_remote_item item;
        item.func = func;
        item.len  = len;
        item.b0   = b0;
        item.b1   = b1;
        item.b2   = b2;
        item.b3   = b3;
        item.mask = mask;
        return item;
    endfunction

    // offer one item from a falling edge and hold it until the transfer happens;
    // valid is written at falling edges and dips only for a random idle gap
    task automatic send_item(input t_remote_item item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid            = 1'b1;
        in_ch.func             = item.func;
        in_ch.report_length    = item.len;
        in_ch.byte_zero        = item.b0;
        in_ch.byte_one         = item.b1;
        in_ch.byte_two         = item.b2;
        in_ch.byte_three       = item.b3;
        in_ch.click_clear_mask = item.mask;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // random reports come in bursts that stay in one device mode, so the
    // decoder actually reaches its mode-specific rules; a burst opens with a
    // signature report of its mode, and noise and non-report items are mixed in
    task automatic next_random_item(output t_remote_item item);
        int   roll;
        int   sel;
        logic entry;
        item.func = FUNC_REPORT;
        item.len  = 4'($urandom_range(0, 15));
        item.b0   = 8'($urandom_range(0, 255));
        item.b1   = 8'($urandom_range(0, 255));
        item.b2   = 8'($urandom_range(0, 255));
        item.b3   = 8'($urandom_range(0, 255));
        item.mask = 10'($urandom_range(0, 1023));
        entry = (burst_left == 0);
        if (entry) begin
            burst_kind = t_burst_kind'($urandom_range(0, 2));
            burst_left = $urandom_range(4, 14);
        end else begin
            burst_left--;
        end
        roll = entry ? 99 : $urandom_range(0, 99);
        if (roll < 8) begin
            item.func = FUNC_READ_CLICKS;
        end else if (roll < 11) begin
            item.func = FUNC_DISCONNECT;
        end else if (roll < 13) begin
            item.func = FUNC_RESERVED;
        end else if (roll < 23) begin
            // noise: any length, any bytes
        end else begin
            case (burst_kind)
                BURST_A: begin
                    sel = entry ? $urandom_range(3, 5) : $urandom_range(0, 7);
                    item.len = (sel < 6) ? 4'd1 : 4'd2;
                    case (sel)
                        0: item.b0 = 8'h00;
                        1: item.b0 = 8'h01;
                        2: item.b0 = 8'h02;
                        3: item.b0 = 8'h04;
                        4: item.b0 = 8'h10;
                        5: item.b0 = 8'h20;
                        6: begin
                            item.b0 = 8'h00;
                            item.b1 = TAG_KEY;
                        end
                        default: begin
                            item.b0 = 8'h02;
                            item.b1 = TAG_KEY;
                        end
                    endcase
                end
                BURST_B: begin
                    // the first four pairs are the ones that announce mode B
                    sel = entry ? $urandom_range(0, 3) : $urandom_range(0, 10);
                    item.len = 4'd2;
                    case (sel)
                        0: begin item.b0 = 8'h10; item.b1 = TAG_KEY_A; end
                        1: begin item.b0 = 8'h08; item.b1 = TAG_KEY_C; end
                        2: begin item.b0 = 8'h80; item.b1 = TAG_KEY;   end
                        3: begin item.b0 = 8'h40; item.b1 = TAG_KEY;   end
                        4: begin item.b0 = 8'h00; item.b1 = TAG_KEY;   end
                        5: begin item.b0 = 8'h01; item.b1 = TAG_KEY;   end
                        6: begin item.b0 = 8'h02; item.b1 = TAG_KEY;   end
                        7: begin item.b0 = 8'h00; item.b1 = JOY_UP;    end
                        8: begin item.b0 = 8'h00; item.b1 = JOY_DOWN;  end
                        9: begin item.b0 = 8'h00; item.b1 = JOY_LEFT;  end
                        default: begin item.b0 = 8'h00; item.b1 = JOY_RIGHT; end
                    endcase
                end
                default: begin
                    sel = entry ? $urandom_range(6, 11) : $urandom_range(0, 11);
                    if (sel < 3) begin
                        item.len = 4'd1;
                        item.b0  = 8'(sel);
                    end else if (sel < 6) begin
                        item.len = 4'd2;
                        item.b0  = 8'(sel - 3);
                        item.b1  = TAG_KEY;
                    end else begin
                        // four byte reports: exact patterns or the axis fallback
                        item.len = 4'd4;
                        case ($urandom_range(0, 3))
                            0: item.b0 = 8'h00;
                            1: item.b0 = 8'h01;
                            2: item.b0 = 8'h02;
                            default: ;
                        endcase
                        case ($urandom_range(0, 5))
                            0: begin
                                item.b1 = 8'h00;
                                item.b2 = 8'h00;
                                item.b3 = 8'h00;
                            end
                            1: item.b1 = AXIS_NEG;
                            2: item.b1 = AXIS_POS;
                            3: item.b2 = AXIS_NEG;
                            4: item.b2 = AXIS_POS;
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    endtask

    // receiver: random stalls, plus long hold-offs when the stimulus asks
    initial begin : receiver
        int hold_left;
        hold_left     = 0;
        holds_done    = 0;
        out_ch.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // hang detection: nothing moving on either channel for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_remote_item item;
        i_rst_n                = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.func             = FUNC_REPORT;
        in_ch.report_length    = '0;
        in_ch.byte_zero        = '0;
        in_ch.byte_one         = '0;
        in_ch.byte_two         = '0;
        in_ch.byte_three       = '0;
        in_ch.click_clear_mask = '0;
        send_idle_pct          = 0;
        stall_pct              = 0;
        holds_asked            = 0;
        burst_kind             = BURST_A;
        burst_left             = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed walk: reserved code and field extremes, unknown-mode rules,
        // then modes A, B and D each entered, exercised and left again
        send_item(pack_item(FUNC_RESERVED, 4'd15, 8'hff, 8'hff, 8'hff, 8'hff, 10'h3ff));
        // joystick press while the mode is unknown
        send_item(pack_item(FUNC_REPORT, 4'd2, 8'h00, JOY_UP, 8'h00, 8'h00, 10'h000));
        // undecoded length in unknown mode clears and is not flagged
        send_item(pack_item(FUNC_REPORT, 4'd0, 8'hff, 8'hff, 8'hff, 8'hff, 10'h000));
        // mode A, with junk in the bytes past the length
        send_item(pack_item(FUNC_REPORT, 4'd1, 8'h04, 8'haa, 8'h55, 8'hff, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd1, 8'h01, 8'h00, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd1, 8'h02, 8'h00, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd2, 8'h02, TAG_KEY, 8'h00, 8'h00, 10'h000));
        // undecoded length in a known mode is flagged
        send_item(pack_item(FUNC_REPORT, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd1, 8'hff, 8'h00, 8'h00, 8'h00, 10'h000));
        // partial and full click clears
        send_item(pack_item(FUNC_READ_CLICKS, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 10'h155));
        send_item(pack_item(FUNC_READ_CLICKS, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 10'h3ff));
        send_item(pack_item(FUNC_REPORT, 4'd1, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000));
        // joystick contradicts mode A
        send_item(pack_item(FUNC_REPORT, 4'd2, 8'h00, JOY_RIGHT, 8'h00, 8'h00, 10'h000));
        // mode B
        send_item(pack_item(FUNC_REPORT, 4'd2, 8'h10, TAG_KEY_A, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd2, 8'h01, TAG_KEY, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd2, 8'h00, JOY_DOWN, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd2, 8'h00, TAG_KEY, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd1, 8'h02, 8'h00, 8'h00, 8'h00, 10'h000));
        // mode D and its four byte fallback
        send_item(pack_item(FUNC_REPORT, 4'd4, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd4, 8'h01, 8'h00, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd4, 8'h01, AXIS_NEG, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd4, 8'h00, 8'h33, AXIS_POS, 8'h77, 10'h000));
        // fallback with no direction byte is flagged
        send_item(pack_item(FUNC_REPORT, 4'd4, 8'h01, 8'h12, 8'h34, 8'h56, 10'h000));
        send_item(pack_item(FUNC_REPORT, 4'd2, 8'h02, TAG_KEY, 8'h00, 8'h00, 10'h000));
        send_item(pack_item(FUNC_DISCONNECT, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 10'h000));

        // random phases: free flow, sender gaps, receiver stalls, both, then
        // repeated long hold-offs against a sender that never pauses
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                3: begin send_idle_pct = 31; stall_pct = 31; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 4 && n % 40 == 0) holds_asked++;
                next_random_item(item);
                send_item(item);
            end
        end
        in_ch.valid = 1'b0;

        // wait out the results still in flight, then a little longer
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/rrd_pkg.sv
sv/rrd_ifs.sv
sv/rrd_front.sv
sv/rrd_queue.sv
sv/rrd_back.sv
sv/ring_remote_report_decoder_top.sv
verif/rrd_report_checker.sv
verif/tb_ring_remote_report_decoder_top.sv
